[src/lfc_pkg.sv]
package lfc_pkg;

    // Default geometry of the cache.
    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // Capacity register.
    localparam int              CAP_BITS  = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // latch the incoming item
        logic compare;  // parallel key and rank compare
        logic select;   // pick the slot and read its value
        logic commit;   // update state and register the result
    } t_cmd;

endpackage

[src/lfc_ram.sv]
module lfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/lfc_ctrl.sv]
module lfc_ctrl
    import lfc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_COMPARE = 2'd1;
    localparam logic [1:0] ST_SELECT  = 2'd2;
    localparam logic [1:0] ST_COMMIT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       busy;

    assign busy = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_COMPARE;
                end
            end
            ST_COMPARE: n_state = ST_SELECT;
            ST_SELECT:  n_state = ST_COMMIT;
            ST_COMMIT:  n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy          = busy;
    assign o_cmd.load      = i_start && !busy;
    assign o_cmd.compare   = (r_state == ST_COMPARE);
    assign o_cmd.select    = (r_state == ST_SELECT);
    assign o_cmd.commit    = (r_state == ST_COMMIT);

endmodule

[src/lfc_dp.sv]
module lfc_dp
    import lfc_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic                  i_cfg_we,
    input  logic [CAP_BITS-1:0]   i_cfg_data,
    input  logic [KEY_BITS-1:0]   i_lookup_key,
    input  logic [VALUE_BITS-1:0] i_fill_value,
    output logic                  o_valid,
    output logic [VALUE_BITS-1:0] o_result_value,
    output logic                  o_hit,
    output logic                  o_evicted,
    output logic [KEY_BITS-1:0]   o_evicted_key,
    output logic [VALUE_BITS-1:0] o_evicted_value
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int LW = (CW > CAP_BITS) ? CW : CAP_BITS;

    // Item and configuration.
    logic [KEY_BITS-1:0]   r_key_in;
    logic [VALUE_BITS-1:0] r_fill_in;
    logic [CAP_BITS-1:0]   r_capacity;

    // Entry state: keys live in flops so all of them compare at once.
    logic [ENTRIES-1:0]    r_valid_vec;
    logic [IW-1:0]         r_rank [ENTRIES];
    logic [KEY_BITS-1:0]   r_keys [ENTRIES];
    logic [CW-1:0]         r_count;

    // Compare stage results.
    logic [ENTRIES-1:0]    r_hit_oh;
    logic [ENTRIES-1:0]    r_vic_oh;
    logic [ENTRIES-1:0]    r_free_oh;
    logic                  r_hit;
    logic                  r_evict;
    logic                  r_empty;

    // Select stage results.
    logic [IW-1:0]         r_slot;
    logic [IW-1:0]         r_hit_rank;
    logic [KEY_BITS-1:0]   r_vic_key;

    // Result registers.
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_value;
    logic                  r_out_hit;
    logic                  r_out_evicted;
    logic [KEY_BITS-1:0]   r_out_ekey;
    logic [VALUE_BITS-1:0] r_out_evalue;

    logic [ENTRIES-1:0]    n_hit_oh;
    logic [ENTRIES-1:0]    n_vic_oh;
    logic [ENTRIES-1:0]    n_free_oh;
    logic [ENTRIES-1:0]    free_vec;
    logic [CW-1:0]         count_m1;
    logic [LW-1:0]         cap_eff;
    logic [IW-1:0]         hit_idx;
    logic [IW-1:0]         vic_idx;
    logic [IW-1:0]         free_idx;
    logic [IW-1:0]         n_slot;
    logic [IW-1:0]         n_hit_rank;
    logic [KEY_BITS-1:0]   n_vic_key;
    logic [VALUE_BITS-1:0] ram_rdata;
    logic                  ram_we;
    logic                  self_evict;

    // ---------------- compare ----------------
    assign count_m1 = r_count - CW'(1);
    assign free_vec = ~r_valid_vec;
    assign n_free_oh = free_vec & (~free_vec + ENTRIES'(1));
    assign cap_eff  = (LW'(r_capacity) > LW'(ENTRIES)) ? LW'(ENTRIES) : LW'(r_capacity);

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            n_hit_oh[i] = r_valid_vec[i] && (r_keys[i] == r_key_in);
            n_vic_oh[i] = r_valid_vec[i] && (CW'(r_rank[i]) == count_m1);
        end
    end

    // ---------------- select ----------------
    always_comb begin
        hit_idx    = '0;
        vic_idx    = '0;
        free_idx   = '0;
        n_hit_rank = '0;
        n_vic_key  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_hit_oh[i]) begin
                hit_idx    = hit_idx | IW'(i);
                n_hit_rank = n_hit_rank | r_rank[i];
            end
            if (r_vic_oh[i]) begin
                vic_idx   = vic_idx | IW'(i);
                n_vic_key = n_vic_key | r_keys[i];
            end
            if (r_free_oh[i]) begin
                free_idx = free_idx | IW'(i);
            end
        end
        if (r_hit) begin
            n_slot = hit_idx;
        end else if (r_evict) begin
            n_slot = vic_idx;
        end else begin
            n_slot = free_idx;
        end
    end

    // With an empty cache and capacity zero the new item is the victim.
    assign self_evict = !r_hit && r_evict && r_empty;
    assign ram_we     = i_cmd.commit && !r_hit && !self_evict;

    lfc_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_fill_in),
        .i_raddr (n_slot),
        .o_rdata (ram_rdata)
    );

    // ---------------- control and entry state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_valid_vec <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_out_valid <= i_cmd.commit;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (ram_we && !r_evict) begin
                r_valid_vec[r_slot] <= 1'b1;
                r_count             <= r_count + CW'(1);
            end
            if (i_cmd.commit && !self_evict) begin
                // Promote the slot: entries more recent than its old rank age
                // by one. A fill or replacement ages every other entry.
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IW'(i) == r_slot) begin
                        r_rank[i] <= '0;
                    end else if (r_valid_vec[i] && (!r_hit || r_rank[i] < r_hit_rank)) begin
                        r_rank[i] <= r_rank[i] + IW'(1);
                    end
                end
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key_in  <= i_lookup_key;
            r_fill_in <= i_fill_value;
        end
        if (i_cmd.compare) begin
            r_hit_oh  <= n_hit_oh;
            r_vic_oh  <= n_vic_oh;
            r_free_oh <= n_free_oh;
            r_hit     <= |n_hit_oh;
            r_evict   <= (LW'(r_count) >= cap_eff);
            r_empty   <= (r_count == '0);
        end
        if (i_cmd.select) begin
            r_slot     <= n_slot;
            r_hit_rank <= n_hit_rank;
            r_vic_key  <= n_vic_key;
        end
        if (ram_we) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (IW'(i) == r_slot) begin
                    r_keys[i] <= r_key_in;
                end
            end
        end
        if (i_cmd.commit) begin
            r_out_hit     <= r_hit;
            r_out_value   <= r_hit ? ram_rdata : r_fill_in;
            r_out_evicted <= !r_hit && r_evict;
            if (r_hit || !r_evict) begin
                r_out_ekey   <= '0;
                r_out_evalue <= '0;
            end else if (r_empty) begin
                r_out_ekey   <= r_key_in;
                r_out_evalue <= r_fill_in;
            end else begin
                r_out_ekey   <= r_vic_key;
                r_out_evalue <= ram_rdata;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_result_value  = r_out_value;
    assign o_hit           = r_out_hit;
    assign o_evicted       = r_out_evicted;
    assign o_evicted_key   = r_out_ekey;
    assign o_evicted_value = r_out_evalue;

endmodule

[src/lru_lookup_fill_cache.sv]
// Fully associative cache with least-recently-used replacement and fill on
// miss. An item (key and fill value) is taken when start is high while busy is
// low. Busy then stays high while the key is compared against every stored
// entry in parallel, the slot is chosen and its value is read from the value
// memory, and the ranks are updated. The result appears on the output ports
// for exactly one cycle, marked by o_valid, once the item is through the
// compare, select and commit steps, and the receiver cannot stall it. A new
// item may be started in that same cycle; the block takes no new item while
// one is still in its compare, select and commit steps around the registered
// read of the value memory. On a hit the stored value is returned and the
// entry becomes the most recent. On a miss the fill value is stored as the
// most recent entry and returned; when the entry count has reached the
// capacity, the least recent entry is replaced and reported as evicted. With
// capacity zero and an empty cache the new item itself is reported as
// evicted and nothing is stored. Capacities above the number of entries act
// as the number of entries. Write the capacity register only while the block
// is idle.
module lru_lookup_fill_cache
    import lfc_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cfg_we,
    input  logic [CAP_BITS-1:0]   i_cfg_data,
    input  logic [KEY_BITS-1:0]   i_lookup_key,
    input  logic [VALUE_BITS-1:0] i_fill_value,
    output logic                  o_valid,
    output logic [VALUE_BITS-1:0] o_result_value,
    output logic                  o_hit,
    output logic                  o_evicted,
    output logic [KEY_BITS-1:0]   o_evicted_key,
    output logic [VALUE_BITS-1:0] o_evicted_value
);

    t_cmd cmd;

    // The controller sequences each item through its three working steps.
    lfc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // The datapath holds the entries, the ranks and the result registers.
    lfc_dp #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_lookup_key    (i_lookup_key),
        .i_fill_value    (i_fill_value),
        .o_valid         (o_valid),
        .o_result_value  (o_result_value),
        .o_hit           (o_hit),
        .o_evicted       (o_evicted),
        .o_evicted_key   (o_evicted_key),
        .o_evicted_value (o_evicted_value)
    );

endmodule

[sim/tb_lru_lookup_fill_cache.sv]
`timescale 1ns / 1ps

module tb_lru_lookup_fill_cache
    import lfc_pkg::*;
();

    // Self-checking testbench for the fully associative LRU lookup-and-fill
    // cache. Every item that the block accepts is run through a shadow copy of
    // the cache in the testbench. The predicted result is queued and compared
    // field by field with the next result that the block strobes out.

    localparam int CLK_PERIOD    = 10;
    localparam int ENTRIES       = ENTRIES_DEF;
    localparam int KEY_BITS      = KEY_BITS_DEF;
    localparam int VALUE_BITS    = VALUE_BITS_DEF;
    // A result leaves the block after the compare, select and commit steps of
    // its item, so this many quiet cycles are enough for it to be fully idle.
    localparam int SETTLE_CYCLES = 6;
    // The slowest correct run is about 800 items with idle gaps between some
    // of them. This limit is far beyond it.
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int MAX_REPORTS   = 10;
    localparam int POOL_SIZE     = 24;
    localparam int PHASE_ITEMS   = 95;

    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [VALUE_BITS-1:0] t_value;

    // One expected result of a lookup.
    typedef struct packed {
        t_value value;
        logic   hit;
        logic   evicted;
        t_key   ev_key;
        t_value ev_value;
    } t_lookup_result;

    // Every input is known from time zero.
    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                start        = 1'b0;
    logic                i_cfg_we     = 1'b0;
    logic [CAP_BITS-1:0] i_cfg_data   = '0;
    t_key                i_lookup_key = '0;
    t_value              i_fill_value = '0;

    logic   busy;
    logic   o_valid;
    t_value o_result_value;
    logic   o_hit;
    logic   o_evicted;
    t_key   o_evicted_key;
    t_value o_evicted_value;

    lru_lookup_fill_cache #(
        .ENTRIES   (ENTRIES),
        .KEY_BITS  (KEY_BITS),
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_lookup_key   (i_lookup_key),
        .i_fill_value   (i_fill_value),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_hit          (o_hit),
        .o_evicted      (o_evicted),
        .o_evicted_key  (o_evicted_key),
        .o_evicted_value(o_evicted_value)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow copy of the cache contents and of the capacity register. Rank 0
    // is the most recently used valid entry; the oldest has rank count-1.
    logic                shadow_valid [ENTRIES];
    t_key                shadow_key   [ENTRIES];
    t_value              shadow_value [ENTRIES];
    int unsigned         shadow_rank  [ENTRIES];
    logic [CAP_BITS-1:0] shadow_capacity;

    // Results predicted for accepted items, oldest first.
    t_lookup_result pending_results[$];

    int error_count = 0;
    int cycle_count = 0;

    initial begin
        shadow_capacity = CAP_RESET;
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
            shadow_rank[i]  = 0;
        end
    end

    // Make slot s the most recent one. Every other valid entry whose rank is
    // below the limit ages by one step.
    function automatic void make_most_recent(input int s, input int unsigned limit);
        for (int i = 0; i < ENTRIES; i++) begin
            if (shadow_valid[i] && i != s && shadow_rank[i] < limit) begin
                shadow_rank[i]++;
            end
        end
        shadow_rank[s] = 0;
    endfunction

    // Apply one lookup to the shadow cache and return the result it causes.
    function automatic t_lookup_result lru_lookup(input t_key key, input t_value fill);
        t_lookup_result res;
        int unsigned    count;
        int unsigned    limit;
        int             slot;
        res   = '0;
        count = 0;
        slot  = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (shadow_valid[i]) begin
                count++;
            end
            if (slot < 0 && shadow_valid[i] && shadow_key[i] == key) begin
                slot = i;
            end
        end

        // A hit returns the stored value and only touches the ranks of the
        // entries that were more recent than the one that hit.
        if (slot >= 0) begin
            res.value = shadow_value[slot];
            res.hit   = 1'b1;
            make_most_recent(slot, shadow_rank[slot]);
            return res;
        end

        // Capacities above the storage size behave as the storage size.
        limit     = (shadow_capacity > ENTRIES) ? ENTRIES : shadow_capacity;
        res.value = fill;

        if (count + 1 > limit) begin
            res.evicted = 1'b1;
            // With nothing stored and zero capacity, the new item itself is
            // the one that gets evicted, and nothing is kept.
            if (count == 0) begin
                res.ev_key   = key;
                res.ev_value = fill;
                return res;
            end
            // Otherwise the least recent entry is replaced in place.
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot < 0 && shadow_valid[i] && shadow_rank[i] == count - 1) begin
                    slot = i;
                end
            end
            if (slot < 0) begin
                slot = 0;
            end
            res.ev_key   = shadow_key[slot];
            res.ev_value = shadow_value[slot];
        end else begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot < 0 && !shadow_valid[i]) begin
                    slot = i;
                end
            end
            if (slot < 0) begin
                return res;
            end
            shadow_valid[slot] = 1'b1;
        end
        shadow_key[slot]   = key;
        shadow_value[slot] = fill;
        make_most_recent(slot, ENTRIES);
        return res;
    endfunction

    // Global cycle limit. Reaching it means the block stopped taking items or
    // stopped producing results.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("lru_lookup_fill_cache test failed");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string field, input logic [63:0] expected,
                               input logic [63:0] actual);
        if (actual !== expected) begin
            report_error($sformatf("%s mismatch: expected 0x%0h, got 0x%0h",
                                   field, expected, actual));
        end
    endtask

    // Result checker. The strobe is sampled at the edge that ends its cycle;
    // outputs read right after the edge still hold their pre-edge values.
    always @(posedge i_clk) begin
        t_lookup_result exp_res;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_error("result strobed with no item outstanding");
            end else begin
                exp_res = pending_results.pop_front();
                check_field("result_value", 64'(exp_res.value), 64'(o_result_value));
                check_field("hit", 64'(exp_res.hit), 64'(o_hit));
                check_field("evicted", 64'(exp_res.evicted), 64'(o_evicted));
                check_field("evicted_key", 64'(exp_res.ev_key), 64'(o_evicted_key));
                check_field("evicted_value", 64'(exp_res.ev_value),
                            64'(o_evicted_value));
            end
        end
    end

    // Offer one item and hold it until the block takes it. The item is taken
    // at the first edge where start is high and busy was low just before it.
    // Start stays high on return, so a following item goes out back to back.
    task automatic send_lookup(input t_key key, input t_value fill);
        start        <= 1'b1;
        i_lookup_key <= key;
        i_fill_value <= fill;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(lru_lookup(key, fill));
    endtask

    // Leave the block without a new item for a few cycles. The payload moves
    // meanwhile, since it must be ignored while start is low.
    task automatic idle_cycles(input int n);
        start        <= 1'b0;
        i_lookup_key <= $urandom;
        i_fill_value <= $urandom;
        repeat (n) @(posedge i_clk);
    endtask

    // The capacity may only change while the block is idle: every outstanding
    // result must have come back, and the pipeline is given time to drain.
    task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we        <= 1'b0;
        shadow_capacity = cap;
    endtask

    // Zero capacity straight after reset: every miss evicts its own item, so
    // even a repeated key misses again.
    task automatic test_zero_capacity_empty();
        write_capacity('0);
        send_lookup('0, '1);
        send_lookup('1, '0);
        send_lookup('0, 32'h1234_5678);
    endtask

    // Fill four entries, touch the oldest one, then force replacements of the
    // least recent entry. Keys and values hit their extremes on the way.
    task automatic test_fill_and_replace();
        write_capacity(CAP_BITS'(4));
        send_lookup(32'h0000_0000, 32'hFFFF_FFFF);
        send_lookup(32'hFFFF_FFFF, 32'h0000_0000);
        send_lookup(32'h0000_0001, 32'h8000_0000);
        idle_cycles(2);
        send_lookup(32'h8000_0000, 32'h0000_0001);
        send_lookup(32'h0000_0000, 32'h5555_5555);
        send_lookup(32'hAAAA_AAAA, 32'hAAAA_AAAA);
        send_lookup(32'hFFFF_FFFF, 32'h5555_5555);
    endtask

    // Capacity dropped below the entry count: nothing is dropped at once, each
    // miss swaps out the least recent entry, and hits evict nothing.
    task automatic test_capacity_lowered();
        write_capacity(CAP_BITS'(1));
        send_lookup(32'h7FFF_FFFF, 32'hDEAD_BEEF);
        send_lookup(32'h7FFF_FFFF, 32'h0000_0000);
        send_lookup(32'h0000_0000, 32'h1111_1111);
    endtask

    // Zero capacity with entries present replaces the least recent entry.
    task automatic test_zero_capacity_occupied();
        write_capacity('0);
        send_lookup(32'h0F0F_0F0F, 32'hF0F0_F0F0);
        send_lookup(32'hF0F0_F0F0, 32'h0F0F_0F0F);
        send_lookup(32'h0F0F_0F0F, 32'h0000_0000);
    endtask

    // One phase of random traffic at a fixed capacity. Most keys come from a
    // small pool so that hits, refills and evictions all happen often; the
    // rest are fully random keys that nearly always miss.
    task automatic run_random_phase(input logic [CAP_BITS-1:0] cap, input int n_items,
                                    input bit with_gaps);
        t_key key_pool[POOL_SIZE];
        t_key key;
        bit   quiet;
        write_capacity(cap);
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end
        quiet = 1'b0;
        for (int n = 0; n < n_items; n++) begin
            // Gaps come and go in stretches, so some runs of items are back
            // to back and others are broken up at every phase of the work.
            if ($urandom_range(0, 15) == 0) begin
                quiet = ~quiet;
            end
            if (with_gaps && !quiet && $urandom_range(0, 2) == 0) begin
                idle_cycles($urandom_range(1, 6));
            end
            if ($urandom_range(0, 9) < 7) begin
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else begin
                key = $urandom;
            end
            send_lookup(key, $urandom);
        end
    endtask

    // Random traffic over a range of capacities, including the largest
    // register value, values above the storage size, and raising and lowering
    // the capacity while entries are held.
    task automatic test_random_traffic();
        run_random_phase(CAP_BITS'(16), PHASE_ITEMS, 1'b1);
        run_random_phase(CAP_BITS'(2), PHASE_ITEMS, 1'b1);
        run_random_phase('1, PHASE_ITEMS, 1'b1);
        run_random_phase('0, PHASE_ITEMS, 1'b1);
        run_random_phase(CAP_BITS'(17), PHASE_ITEMS, 1'b1);
        run_random_phase(CAP_BITS'(1), PHASE_ITEMS, 1'b1);
        run_random_phase(CAP_BITS'($urandom_range(0, 31)), PHASE_ITEMS, 1'b1);
    endtask

    // The last stretch runs at full rate with no gaps at all.
    task automatic test_back_to_back();
        run_random_phase(CAP_BITS'(8), PHASE_ITEMS, 1'b0);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_capacity_empty();
        test_fill_and_replace();
        test_capacity_lowered();
        test_zero_capacity_occupied();
        test_random_traffic();
        test_back_to_back();

        // Drain: wait for every outstanding result, then watch a few more
        // cycles for stray strobes.
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("lru_lookup_fill_cache test passed");
        end else begin
            $display("lru_lookup_fill_cache test failed");
        end
        $finish;
    end

endmodule
